@@ hw/rtl/rmfb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmfb_pkg
// Shared codes and the command/status bundles between the framebuffer
// controller and its datapath.
// ----------------------------------------------------------------------------
package rmfb_pkg;

    // Operation codes carried in the input tuser
    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_FILL   = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Rotation register codes, quarter turns
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [7:0] BYTE_BLACK = 8'hFF;
    localparam logic [7:0] BYTE_WHITE = 8'h00;
    localparam logic [7:0] BYTE_BLANK = 8'hFF;
    localparam logic [7:0] MASK_MSB   = 8'h80;

    typedef struct packed {
        logic capture;     // latch the accepted input beat
        logic map_step;    // rotate and bounds-check the point
        logic addr_step;   // form the byte address and bit mask
        logic pix_rd;      // read the byte at the pixel address
        logic pix_wr;      // write back the modified byte
        logic byte_rd;     // read the byte at the raster index
        logic fill_init;   // restart the fill sweep
        logic fill_wr;     // write one fill byte, advance
        logic out_load;    // load the output register
    } cmd_t;

    typedef struct packed {
        logic pix_ok;      // pixel address lies inside the store
        logic fill_last;   // fill sweep at its final byte
        logic out_free;    // output register can take a byte
    } status_t;

endpackage : rmfb_pkg
`default_nettype wire

@@ hw/rtl/rotated_mono_framebuffer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_mono_framebuffer
// Pixel write: map, address with one row multiply, read, write back through
//   the frame store write port; a dropped point skips the read and the write
//   back; no result.
// Fill: one store byte per cycle across all PANEL_WIDTH*PANEL_HEIGHT/8 bytes.
// Byte read: the beat is captured, the store byte read, then the result loaded
//   into the output register; the next beat is taken after that load, later
//   while the previous byte still waits on the panel side.
// Reset clears control, rotation and fill count; the store is undefined until filled.
// ----------------------------------------------------------------------------
module rotated_mono_framebuffer
    import rmfb_pkg::*;
#(
    parameter int PANEL_WIDTH  = 200,
    parameter int PANEL_HEIGHT = 200
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pixel_x[8:0], pixel_y[17:9], colour[33:18], byte_index[46:34], zero pad
    input  wire logic [47:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // panel_byte[7:0]
    output logic [7:0]       m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    rmfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_func  (s_tuser),
        .in_ready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    rmfb_datapath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .pixel_x    (s_tdata[8:0]),
        .pixel_y    (s_tdata[17:9]),
        .colour     (s_tdata[33:18]),
        .byte_index (s_tdata[46:34]),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

`ifndef SYNTHESIS
    a_no_write_while_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(cmd.pix_wr || cmd.fill_wr))
        else $error("store write while accepting a beat");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten");

    a_read_issues: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == FUNC_READ) |=> cmd.byte_rd)
        else $error("read beat did not reach the store");

    a_write_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == FUNC_WRITE) |=> cmd.map_step ##1 cmd.addr_step)
        else $error("pixel write sequence broken");
`endif

endmodule : rotated_mono_framebuffer
`default_nettype wire

@@ hw/rtl/rmfb_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmfb_ctrl
// Sequencer for the framebuffer: accepts one beat at a time and steps the
// datapath through pixel read-modify-write, fill sweep or byte read.
// ----------------------------------------------------------------------------
module rmfb_ctrl
    import rmfb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_func,
    output logic            in_ready,
    output cmd_t            cmd,
    input  status_t         status
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAP  = 3'd1;
    localparam logic [2:0] ST_ADDR = 3'd2;
    localparam logic [2:0] ST_PRD  = 3'd3;
    localparam logic [2:0] ST_PWB  = 3'd4;
    localparam logic [2:0] ST_FILL = 3'd5;
    localparam logic [2:0] ST_BRD  = 3'd6;
    localparam logic [2:0] ST_BOUT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (in_func)
                        FUNC_WRITE: state_next = ST_MAP;
                        FUNC_FILL:
                        begin
                            cmd.fill_init = 1'b1;
                            state_next    = ST_FILL;
                        end
                        FUNC_READ:  state_next = ST_BRD;
                        default:    state_next = ST_IDLE;  // drop unused code
                    endcase
                end
            end
            ST_MAP:
            begin
                cmd.map_step = 1'b1;
                state_next   = ST_ADDR;
            end
            ST_ADDR:
            begin
                cmd.addr_step = 1'b1;
                state_next    = ST_PRD;
            end
            ST_PRD:
            begin
                cmd.pix_rd = status.pix_ok;
                state_next = status.pix_ok ? ST_PWB : ST_IDLE;
            end
            ST_PWB:
            begin
                cmd.pix_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BRD:
            begin
                cmd.byte_rd = 1'b1;
                state_next  = ST_BOUT;
            end
            ST_BOUT:
            begin
                // hold until the output register frees up
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : rmfb_ctrl
`default_nettype wire

@@ hw/rtl/rmfb_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmfb_datapath
// Frame store, rotation mapping, byte addressing, fill counter, rotation
// register and output register.
// ----------------------------------------------------------------------------
module rmfb_datapath
    import rmfb_pkg::*;
#(
    parameter int PANEL_WIDTH  = 200,
    parameter int PANEL_HEIGHT = 200
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  cmd_t             cmd,
    output status_t          status,
    input  wire logic [8:0]  pixel_x,
    input  wire logic [8:0]  pixel_y,
    input  wire logic [15:0] colour,
    input  wire logic [12:0] byte_index,
    input  wire logic        cfg_valid,
    input  wire logic [1:0]  cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_data
);

    localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CNT_W       = $clog2(STORE_BYTES + 1);
    localparam logic [8:0]  W9       = 9'(PANEL_WIDTH);
    localparam logic [8:0]  H9       = 9'(PANEL_HEIGHT);
    localparam logic [14:0] STORE15  = 15'(STORE_BYTES);
    localparam logic [CNT_W-1:0] FILL_END = CNT_W'(STORE_BYTES - 1);

    logic [7:0] mem [STORE_BYTES];

    logic [1:0]  rotation_reg;
    logic [8:0]  x_reg;
    logic [8:0]  y_reg;
    logic        black_reg;
    logic [12:0] bidx_reg;
    logic [7:0]  px_reg;
    logic [7:0]  py_reg;
    logic        map_ok_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]  mask_reg;
    logic        pix_ok_reg;
    logic [7:0]  rdata_reg;
    logic        byte_in_reg;
    logic [CNT_W-1:0] fill_cnt_reg;
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;

    logic [8:0]  xu;
    logic [8:0]  yu;
    logic [8:0]  lw;
    logic [8:0]  lh;
    logic [8:0]  px9;
    logic [8:0]  py9;
    logic        map_ok;
    logic [16:0] row_prod;
    logic [14:0] idx;
    logic        bidx_in;
    logic        mem_we;
    logic        mem_re;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]  wr_data;
    logic [7:0]  mod_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg <= ROT_0;
        end
        else if (cfg_valid)
        begin
            rotation_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg     <= pixel_x;
            y_reg     <= pixel_y;
            black_reg <= (colour == 16'd0);
            bidx_reg  <= byte_index;
        end
    end

    // Rotate the logical point onto the physical panel
    always_comb
    begin
        xu     = x_reg;
        yu     = y_reg;
        lw     = rotation_reg[0] ? H9 : W9;
        lh     = rotation_reg[0] ? W9 : H9;
        map_ok = !x_reg[8] && !y_reg[8] && (xu < lw) && (yu < lh);
        case (rotation_reg)
            ROT_90:
            begin
                px9 = W9 - yu - 9'd1;
                py9 = xu;
            end
            ROT_180:
            begin
                px9 = W9 - xu - 9'd1;
                py9 = H9 - yu - 9'd1;
            end
            ROT_270:
            begin
                px9 = yu;
                py9 = H9 - xu - 9'd1;
            end
            default:
            begin
                px9 = xu;
                py9 = yu;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.map_step)
        begin
            px_reg     <= px9[7:0];
            py_reg     <= py9[7:0];
            map_ok_reg <= map_ok;
        end
    end

    assign row_prod = 17'(py_reg) * 17'(PANEL_WIDTH);
    assign idx      = 15'(px_reg >> 3) + 15'(row_prod >> 3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_ok_reg <= 1'b0;
        end
        else if (cmd.addr_step)
        begin
            pix_ok_reg <= map_ok_reg && (idx < STORE15);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.addr_step)
        begin
            addr_reg <= idx[ADDR_W-1:0];
            mask_reg <= MASK_MSB >> px_reg[2:0];
        end
    end

    // Fill sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
        end
        else if (cmd.fill_init)
        begin
            fill_cnt_reg <= '0;
        end
        else if (cmd.fill_wr)
        begin
            fill_cnt_reg <= fill_cnt_reg + CNT_W'(1);
        end
    end

    assign bidx_in  = ({1'b0, bidx_reg} < 14'(STORE_BYTES));
    assign mod_byte = black_reg ? (rdata_reg | mask_reg) : (rdata_reg & ~mask_reg);
    assign mem_we   = cmd.pix_wr | cmd.fill_wr;
    assign mem_re   = cmd.pix_rd | (cmd.byte_rd & bidx_in);
    assign wr_addr  = cmd.fill_wr ? fill_cnt_reg[ADDR_W-1:0] : addr_reg;
    assign wr_data  = cmd.fill_wr ? (black_reg ? BYTE_BLACK : BYTE_WHITE) : mod_byte;
    assign rd_addr  = cmd.byte_rd ? bidx_reg[ADDR_W-1:0] : addr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.byte_rd)
        begin
            byte_in_reg <= bidx_in;
        end
    end

    // Output register: load a byte, drop it once the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= byte_in_reg ? ~rdata_reg : BYTE_BLANK;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;
    assign status.pix_ok    = pix_ok_reg;
    assign status.fill_last = (fill_cnt_reg == FILL_END);
    assign status.out_free  = !out_valid_reg || out_ready;

endmodule : rmfb_datapath
`default_nettype wire

@@ test/rmfb_checker.sv @@
// ----------------------------------------------------------------------------
// rmfb_checker
// Watches the pixel/fill/read stream, the panel byte stream and the rotation
// register writes of the rotated framebuffer, keeps its own copy of the frame
// store, and compares every returned panel byte with the oldest one predicted.
// ----------------------------------------------------------------------------
module rmfb_checker
    import rmfb_pkg::*;
#(
    parameter int PANEL_WIDTH  = 200,
    parameter int PANEL_HEIGHT = 200
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // pixel_x[8:0], pixel_y[17:9], colour[33:18], byte_index[46:34], zero pad
    input  logic [47:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // panel_byte[7:0]
    input  logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    output int          errors,
    output int          pending,
    output int          pixels_drawn,
    output int          pixels_dropped,
    output int          fills_seen,
    output int          bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES = PANEL_WIDTH * PANEL_HEIGHT / 8;

    logic [7:0] frame_bytes [STORE_BYTES];
    logic [1:0] rotation = ROT_0;
    logic [7:0] panel_q [$];

    // Map a logical point through the rotation and set or clear its bit.
    function automatic void plot_pixel(logic signed [8:0] x, logic signed [8:0] y,
                                       logic [15:0] colour);
        int lx, ly, lw, lh, px, py, addr;
        logic [7:0] mask;
        lx = x;
        ly = y;
        lw = rotation[0] ? PANEL_HEIGHT : PANEL_WIDTH;
        lh = rotation[0] ? PANEL_WIDTH : PANEL_HEIGHT;
        if (lx < 0 || lx >= lw || ly < 0 || ly >= lh)
        begin
            pixels_dropped++;
            return;
        end
        case (rotation)
            ROT_90:
            begin
                px = PANEL_WIDTH - ly - 1;
                py = lx;
            end
            ROT_180:
            begin
                px = PANEL_WIDTH - lx - 1;
                py = PANEL_HEIGHT - ly - 1;
            end
            ROT_270:
            begin
                px = ly;
                py = PANEL_HEIGHT - lx - 1;
            end
            default:
            begin
                px = lx;
                py = ly;
            end
        endcase
        addr = px / 8 + (py * PANEL_WIDTH) / 8;
        if (px < 0 || py < 0 || addr >= STORE_BYTES)
        begin
            pixels_dropped++;
            return;
        end
        mask = MASK_MSB >> (px & 7);
        if (colour != 16'd0)
            frame_bytes[addr] = frame_bytes[addr] & ~mask;
        else
            frame_bytes[addr] = frame_bytes[addr] | mask;
        pixels_drawn++;
    endfunction

    initial
    begin
        foreach (frame_bytes[i])
            frame_bytes[i] = 8'h00;
    end

    always @(posedge clk)
    begin
        logic [15:0] colour;
        logic [12:0] byte_index;
        logic [7:0]  want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                rotation = cfg_data;

            if (s_tvalid && s_tready)
            begin
                colour     = s_tdata[33:18];
                byte_index = s_tdata[46:34];
                case (s_tuser)
                    FUNC_WRITE:
                        plot_pixel(s_tdata[8:0], s_tdata[17:9], colour);
                    FUNC_FILL:
                    begin
                        foreach (frame_bytes[i])
                            frame_bytes[i] = (colour == 16'd0) ? BYTE_BLACK : BYTE_WHITE;
                        fills_seen++;
                    end
                    FUNC_READ:
                        panel_q.push_back((byte_index < STORE_BYTES) ?
                                          ~frame_bytes[byte_index] : BYTE_BLANK);
                    default:
                        ; // unused selector: drop
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (panel_q.size() == 0)
                begin
                    $error("panel_byte: expected none, actual %02h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = panel_q.pop_front();
                    if (m_tdata !== want)
                    begin
                        $error("panel_byte: expected %02h, actual %02h", want, m_tdata);
                        errors++;
                    end
                    bytes_checked++;
                end
            end
            pending = panel_q.size();
        end
    end

endmodule : rmfb_checker

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel writes, fills, reads and rotation changes into the rotated
// framebuffer with random gaps and stalls on both streams; the checker
// beside the block predicts and compares every panel byte.
// ----------------------------------------------------------------------------
module tb_top
    import rmfb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W           = 200;
    localparam int H           = 200;
    localparam int STORE_BYTES = W * H / 8;
    localparam int DRAIN       = STORE_BYTES + 1 + 32;
    localparam int LIMIT       = 1_000_000;
    localparam int PHASE_ITEMS = 115;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = FUNC_WRITE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = ROT_0;

    int errors, pending, pixels_drawn, pixels_dropped, fills_seen, bytes_checked;
    int unsigned cycles;

    logic [1:0] cur_rot = ROT_0;
    bit         no_idle = 1'b0;
    bit         hold_req = 1'b0;
    int         drawn_bytes [$];

    rotated_mono_framebuffer #(
        .PANEL_WIDTH (W),
        .PANEL_HEIGHT(H)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    rmfb_checker #(
        .PANEL_WIDTH (W),
        .PANEL_HEIGHT(H)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending),
        .pixels_drawn  (pixels_drawn),
        .pixels_dropped(pixels_dropped),
        .fills_seen    (fills_seen),
        .bytes_checked (bytes_checked)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Panel side: random stall before each beat, one long hold on request.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = 300;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Offer one beat after a random gap; return at the negedge after acceptance.
    task automatic send_beat(input logic [1:0] func, input logic [8:0] x,
                             input logic [8:0] y, input logic [15:0] colour,
                             input logic [12:0] byte_index);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {1'b0, byte_index, colour, y, x};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Remember which store byte a drawn point lands in, to steer later reads.
    task automatic draw(input int x, input int y, input logic [15:0] colour);
        int px, py;
        send_beat(FUNC_WRITE, 9'(x), 9'(y), colour, 13'($urandom));
        if (x >= 0 && y >= 0 && x < (cur_rot[0] ? H : W) && y < (cur_rot[0] ? W : H))
        begin
            case (cur_rot)
                ROT_90:  begin px = W - y - 1; py = x;         end
                ROT_180: begin px = W - x - 1; py = H - y - 1; end
                ROT_270: begin px = y;         py = H - x - 1; end
                default: begin px = x;         py = y;         end
            endcase
            drawn_bytes.push_back(px / 8 + py * W / 8);
            if (drawn_bytes.size() > 32)
                void'(drawn_bytes.pop_front());
        end
    endtask

    task automatic read_byte(input int byte_index);
        send_beat(FUNC_READ, 9'($urandom), 9'($urandom), 16'($urandom), 13'(byte_index));
    endtask

    task automatic fill(input logic [15:0] colour);
        send_beat(FUNC_FILL, 9'($urandom), 9'($urandom), colour, 13'($urandom));
    endtask

    // Write the rotation only once the block has drained.
    task automatic set_rotation(input logic [1:0] rot);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= rot;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_rot = rot;
    endtask

    function automatic logic [15:0] pick_colour();
        return $urandom_range(0, 1) ? 16'h0000 : 16'($urandom_range(1, 65535));
    endfunction

    task automatic random_phase(input int n_items);
        int sel;
        repeat (n_items)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                draw($urandom_range(0, (cur_rot[0] ? H : W) - 1),
                     $urandom_range(0, (cur_rot[0] ? W : H) - 1), pick_colour());
            else if (sel < 53)
                draw($signed(9'($urandom)), $signed(9'($urandom)), pick_colour());
            else if (sel < 85 && drawn_bytes.size() > 0)
                read_byte(drawn_bytes[$urandom_range(0, drawn_bytes.size() - 1)]);
            else if (sel < 93)
                read_byte($urandom_range(0, 8191));
            else if (sel < 96)
                fill(pick_colour());
            else
                send_beat(FUNC_UNUSED, 9'($urandom), 9'($urandom), 16'($urandom),
                          13'($urandom));
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: fills, store ends, off-panel points, unused selector.
        set_rotation(ROT_0);
        fill(16'h0000);
        read_byte(0);
        read_byte(STORE_BYTES - 1);
        read_byte(STORE_BYTES);
        read_byte(8191);
        fill(16'hFFFF);
        draw(0, 0, 16'h0000);
        draw(W - 1, H - 1, 16'h0000);
        draw(7, 0, 16'h0000);
        draw(-256, 0, 16'h0000);
        draw(0, -1, 16'h0000);
        draw(W, 5, 16'h0000);
        draw(5, H, 16'h0000);
        draw(255, 255, 16'h0000);
        draw(-1, -256, 16'h0000);
        send_beat(FUNC_UNUSED, 9'h1FF, 9'h1FF, 16'hFFFF, 13'h1FFF);
        read_byte(0);
        read_byte(STORE_BYTES - 1);
        draw(0, 0, 16'h0001);
        draw(W - 1, H - 1, 16'h8000);
        read_byte(0);
        read_byte(STORE_BYTES - 1);
        read_byte(STORE_BYTES + 1);

        set_rotation(ROT_90);
        random_phase(PHASE_ITEMS);
        set_rotation(ROT_180);
        random_phase(PHASE_ITEMS);

        // Run without any idling on either side.
        set_rotation(ROT_270);
        no_idle = 1'b1;
        random_phase(PHASE_ITEMS);
        no_idle = 1'b0;

        // Hold the panel side off while reads keep coming, so the input backs up.
        set_rotation(ROT_0);
        hold_req = 1'b1;
        repeat (24) read_byte($urandom_range(0, 8191));
        random_phase(PHASE_ITEMS);

        set_rotation(ROT_90);
        random_phase(PHASE_ITEMS);

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);

        if (pending != 0)
            $error("panel_byte: %0d expected bytes never arrived", pending);
        $display("Covered all four rotations: %0d pixels drawn, %0d off panel, %0d fills.",
                 pixels_drawn, pixels_dropped, fills_seen);
        $display("Checked %0d panel bytes in %0d cycles.", bytes_checked, cycles);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule : tb_top

@@ files.f @@
hw/rtl/rmfb_pkg.sv
hw/rtl/rmfb_ctrl.sv
hw/rtl/rmfb_datapath.sv
hw/rtl/rotated_mono_framebuffer.sv
test/rmfb_checker.sv
test/tb_top.sv
